@@ sv/ocnc_pkg.sv @@
// Package for the octree child neighbour context select core.
// Holds the context bit set type shared by the selection logic and the top level.
// Depends on nothing.
package ocnc_pkg;

	localparam int unsigned PlaneBitsW = 56;
	localparam int unsigned SiblingW = 7;

	typedef struct packed {
		logic cx;
		logic cy;
		logic cz;
		logic lx;
		logic ly;
		logic lz;
		logic cn;
	} ctx_t;

endpackage

@@ sv/ocnc_select.sv @@
// Combinational context selection for one child of an octree node.
// Picks the seven context bits from the plane bits or the sibling bits.
// Depends on ocnc_pkg.
module ocnc_select
	import ocnc_pkg::*;
(
	input  logic [2:0]            child_index,
	input  logic [2:0]            skip_mask,
	input  logic [PlaneBitsW-1:0] plane_bits,
	input  logic [SiblingW-1:0]   sibling_bits,
	output ctx_t                  ctx
);

	logic dx;
	logic dy;
	logic dz;

	function automatic logic pb(input logic [PlaneBitsW-1:0] v, input int unsigned p,
			input int unsigned c);
		return v[p * 8 + c];
	endfunction

	assign dx = skip_mask[2];
	assign dy = skip_mask[1];
	assign dz = skip_mask[0];

	always_comb begin
		logic [PlaneBitsW-1:0] v;
		logic [SiblingW-1:0]   s;
		v = plane_bits;
		s = sibling_bits;
		ctx = '0;
		case (child_index)
			3'd0: begin
				ctx.cx = pb(v, 0, 4);
				ctx.cy = pb(v, 1, 2);
				ctx.cz = pb(v, 2, 1);
				ctx.lx = pb(v, 5, 3);
				ctx.ly = pb(v, 4, 5);
				ctx.lz = pb(v, 3, 6);
				ctx.cn = pb(v, 6, 7);
			end
			3'd1: begin
				ctx.cx = pb(v, 0, 5);
				ctx.cy = pb(v, 1, 3);
				if (dz) begin
					ctx.cz = pb(v, 2, 1);
					ctx.lx = pb(v, 5, 3);
					ctx.ly = pb(v, 4, 5);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 6, 7);
				end else begin
					ctx.cz = s[0];
					ctx.lx = pb(v, 1, 2);
					ctx.ly = pb(v, 0, 4);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 3, 6);
				end
			end
			3'd2: begin
				ctx.cx = pb(v, 0, 6);
				ctx.cz = pb(v, 2, 3);
				if (dy) begin
					ctx.cy = pb(v, 1, 2);
					ctx.lx = pb(v, 5, 3);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 3, 6);
					ctx.cn = pb(v, 6, 7);
				end else begin
					ctx.cy = s[0];
					ctx.lx = pb(v, 2, 1);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 0, 4);
					ctx.cn = pb(v, 4, 5);
				end
			end
			3'd3: begin
				ctx.cx = pb(v, 0, 7);
				ctx.cy = dy ? pb(v, 1, 3) : s[1];
				ctx.cz = dz ? pb(v, 2, 3) : s[2];
				if (dz) begin
					ctx.lx = pb(v, 2, 1);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 0, 5);
					ctx.cn = pb(v, 4, 5);
				end else if (dy) begin
					ctx.lx = pb(v, 1, 2);
					ctx.ly = pb(v, 0, 6);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 3, 6);
				end else begin
					ctx.lx = s[0];
					ctx.ly = pb(v, 0, 6);
					ctx.lz = pb(v, 0, 5);
					ctx.cn = pb(v, 0, 4);
				end
			end
			3'd4: begin
				ctx.cy = pb(v, 1, 6);
				ctx.cz = pb(v, 2, 5);
				if (dx) begin
					ctx.cx = pb(v, 0, 4);
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 4, 5);
					ctx.lz = pb(v, 3, 6);
					ctx.cn = pb(v, 6, 7);
				end else begin
					ctx.cx = s[0];
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 1, 1);
					ctx.lz = pb(v, 1, 2);
					ctx.cn = pb(v, 5, 3);
				end
			end
			3'd5: begin
				ctx.cx = dx ? pb(v, 0, 5) : s[1];
				ctx.cy = pb(v, 1, 7);
				ctx.cz = dz ? pb(v, 2, 5) : s[4];
				if (dz) begin
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 2, 1);
					ctx.lz = pb(v, 1, 3);
					ctx.cn = pb(v, 5, 3);
				end else if (dx) begin
					ctx.lx = pb(v, 1, 6);
					ctx.ly = pb(v, 0, 4);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 3, 4);
				end else begin
					ctx.lx = pb(v, 1, 6);
					ctx.ly = s[0];
					ctx.lz = pb(v, 1, 3);
					ctx.cn = pb(v, 1, 2);
				end
			end
			3'd6: begin
				ctx.cx = dx ? pb(v, 0, 6) : s[2];
				ctx.cy = dy ? pb(v, 1, 6) : s[4];
				ctx.cz = pb(v, 2, 7);
				if (dx && dy) begin
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 3, 6);
					ctx.cn = pb(v, 6, 7);
				end else if (dx) begin
					ctx.lx = pb(v, 2, 5);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 0, 4);
					ctx.cn = pb(v, 4, 5);
				end else if (dy) begin
					ctx.lx = pb(v, 5, 5);
					ctx.ly = pb(v, 2, 3);
					ctx.lz = pb(v, 1, 2);
					ctx.cn = pb(v, 5, 3);
				end else begin
					ctx.lx = pb(v, 2, 5);
					ctx.ly = pb(v, 2, 3);
					ctx.lz = s[0];
					ctx.cn = pb(v, 2, 1);
				end
			end
			default: begin
				ctx.cx = dx ? pb(v, 0, 7) : s[3];
				ctx.cy = dy ? pb(v, 1, 7) : s[5];
				ctx.cz = dz ? pb(v, 2, 7) : s[6];
				if (dx && dy && dz) begin
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 6, 7);
				end else if (dx && dy) begin
					ctx.lx = pb(v, 1, 6);
					ctx.ly = pb(v, 0, 6);
					ctx.lz = pb(v, 3, 7);
					ctx.cn = pb(v, 3, 6);
				end else if (dx && dz) begin
					ctx.lx = pb(v, 1, 5);
					ctx.ly = pb(v, 4, 7);
					ctx.lz = pb(v, 0, 5);
					ctx.cn = pb(v, 4, 5);
				end else if (dy && dz) begin
					ctx.lx = pb(v, 5, 7);
					ctx.ly = pb(v, 2, 3);
					ctx.lz = pb(v, 0, 3);
					ctx.cn = pb(v, 5, 3);
				end else if (dx) begin
					ctx.lx = s[4];
					ctx.ly = pb(v, 0, 6);
					ctx.lz = pb(v, 0, 5);
					ctx.cn = pb(v, 0, 4);
				end else if (dy) begin
					ctx.lx = pb(v, 1, 6);
					ctx.ly = s[2];
					ctx.lz = pb(v, 1, 3);
					ctx.cn = pb(v, 1, 2);
				end else if (dz) begin
					ctx.lx = pb(v, 2, 5);
					ctx.ly = pb(v, 2, 3);
					ctx.lz = s[1];
					ctx.cn = pb(v, 2, 1);
				end else begin
					ctx.lx = s[4];
					ctx.ly = s[2];
					ctx.lz = s[1];
					ctx.cn = s[0];
				end
			end
		endcase
	end

endmodule

@@ sv/octree_child_neighbour_context_select_core.sv @@
// Octree child neighbour context select core: input register, selection, result register.
// The done strobe comes from the result register, which follows the input register; one transaction per cycle.
// The selection in ocnc_select is the only logic between the two registers; busy stays low.
// Reset (arst_n, asynchronous, active low) clears the valid and done flags only.
// Depends on ocnc_pkg and ocnc_select.
module octree_child_neighbour_context_select_core
	import ocnc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            child_index,
	input  logic [2:0]            skip_mask,
	input  logic [PlaneBitsW-1:0] plane_bits,
	input  logic [SiblingW-1:0]   sibling_bits,
	output logic                  done,
	output logic                  ctx_child_x,
	output logic                  ctx_child_y,
	output logic                  ctx_child_z,
	output logic                  ctx_lean_x,
	output logic                  ctx_lean_y,
	output logic                  ctx_lean_z,
	output logic                  ctx_corner
);

	logic                  valid_s1;
	logic [2:0]            child_index_s1;
	logic [2:0]            skip_mask_s1;
	logic [PlaneBitsW-1:0] plane_bits_s1;
	logic [SiblingW-1:0]   sibling_bits_s1;
	ctx_t                  ctx_sel;
	ctx_t                  ctx_s2;
	logic                  done_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			child_index_s1  <= child_index;
			skip_mask_s1    <= skip_mask;
			plane_bits_s1   <= plane_bits;
			sibling_bits_s1 <= sibling_bits;
		end
		if (valid_s1) begin
			ctx_s2 <= ctx_sel;
		end
	end

	ocnc_select u_select (
		.child_index  (child_index_s1),
		.skip_mask    (skip_mask_s1),
		.plane_bits   (plane_bits_s1),
		.sibling_bits (sibling_bits_s1),
		.ctx          (ctx_sel)
	);

	assign done        = done_s2;
	assign ctx_child_x = ctx_s2.cx;
	assign ctx_child_y = ctx_s2.cy;
	assign ctx_child_z = ctx_s2.cz;
	assign ctx_lean_x  = ctx_s2.lx;
	assign ctx_lean_y  = ctx_s2.ly;
	assign ctx_lean_z  = ctx_s2.lz;
	assign ctx_corner  = ctx_s2.cn;

endmodule

@@ sv/ocnc_checker.sv @@
// Port-level checks for the octree child neighbour context select core.
// Bound to the top level; depends on ocnc_pkg.
module ocnc_checker
	import ocnc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [2:0]            child_index,
	input logic [PlaneBitsW-1:0] plane_bits,
	input logic                  done,
	input logic                  ctx_child_x,
	input logic                  ctx_child_y,
	input logic                  ctx_child_z,
	input logic                  ctx_lean_x,
	input logic                  ctx_lean_y,
	input logic                  ctx_lean_z,
	input logic                  ctx_corner
);

	logic [6:0] ctx_bits;

	assign ctx_bits = {ctx_child_x, ctx_child_y, ctx_child_z, ctx_lean_x, ctx_lean_y,
		ctx_lean_z, ctx_corner};

	// Every accepted transaction produces a result strobe.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("accepted transaction produced no result");

	// No result appears without an earlier accepted transaction.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without an accepted transaction");

	// The result ports hold between results, including before the first one.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (ctx_bits === $past(ctx_bits)))
		else $error("result ports changed without a strobe");

	// Child 0 always takes its x neighbour from plane 0, child 4.
	a_child0_x: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && child_index == 3'd0 |->
			##2 (ctx_child_x == $past(plane_bits[4], 2)))
		else $error("wrong x context for child 0");

endmodule

bind octree_child_neighbour_context_select_core ocnc_checker u_ocnc_checker (.*);

@@ test/octree_child_neighbour_context_select_core_tb.sv @@
// Self-checking testbench for octree_child_neighbour_context_select_core.
// It computes the seven context bits of every child transaction and checks each done strobe.
// Depends on ocnc_pkg and the core with its selection logic.
module octree_child_neighbour_context_select_core_tb;
	import ocnc_pkg::*;

	localparam int unsigned SkipXBit = 2;
	localparam int unsigned SkipYBit = 1;
	localparam int unsigned SkipZBit = 0;
	localparam int unsigned FlushCycles = 4;
	localparam int unsigned DrainLimit = 100;

	typedef struct {
		logic [2:0]            child;
		logic [2:0]            skip;
		logic [PlaneBitsW-1:0] planes;
		logic [SiblingW-1:0]   siblings;
	} child_item_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [2:0]            child_index;
	logic [2:0]            skip_mask;
	logic [PlaneBitsW-1:0] plane_bits;
	logic [SiblingW-1:0]   sibling_bits;
	logic                  done;
	logic                  ctx_child_x;
	logic                  ctx_child_y;
	logic                  ctx_child_z;
	logic                  ctx_lean_x;
	logic                  ctx_lean_y;
	logic                  ctx_lean_z;
	logic                  ctx_corner;

	child_item_t pending_children[$];
	ctx_t        expected_contexts[$];
	int          error_count = 0;
	int          accepted_count = 0;
	int          checked_count = 0;
	int          total_items = 0;
	int          directed_items = 0;
	int          gap_left = 0;
	int          burst_left = 0;

	octree_child_neighbour_context_select_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.child_index  (child_index),
		.skip_mask    (skip_mask),
		.plane_bits   (plane_bits),
		.sibling_bits (sibling_bits),
		.done         (done),
		.ctx_child_x  (ctx_child_x),
		.ctx_child_y  (ctx_child_y),
		.ctx_child_z  (ctx_child_z),
		.ctx_lean_x   (ctx_lean_x),
		.ctx_lean_y   (ctx_lean_y),
		.ctx_lean_z   (ctx_lean_z),
		.ctx_corner   (ctx_corner)
	);

	always #5 clk = ~clk;

	function automatic logic pbit(input logic [PlaneBitsW-1:0] pl, input int p, input int c);
		return pl[p * 8 + c];
	endfunction

	function automatic ctx_t select_context(input logic [2:0] idx, input logic [2:0] sk,
			input logic [PlaneBitsW-1:0] pl, input logic [SiblingW-1:0] s);
		ctx_t r;
		logic dx;
		logic dy;
		logic dz;
		dx = sk[SkipXBit];
		dy = sk[SkipYBit];
		dz = sk[SkipZBit];
		r = '0;
		case (idx)
			3'd0: begin
				r.cx = pbit(pl, 0, 4); r.cy = pbit(pl, 1, 2); r.cz = pbit(pl, 2, 1);
				{r.lx, r.ly, r.lz, r.cn} =
					{pbit(pl, 5, 3), pbit(pl, 4, 5), pbit(pl, 3, 6), pbit(pl, 6, 7)};
			end
			3'd1: begin
				r.cx = pbit(pl, 0, 5); r.cy = pbit(pl, 1, 3);
				if (dz) begin
					r.cz = pbit(pl, 2, 1);
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 3), pbit(pl, 4, 5), pbit(pl, 3, 7), pbit(pl, 6, 7)};
				end else begin
					r.cz = s[0];
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 2), pbit(pl, 0, 4), pbit(pl, 3, 7), pbit(pl, 3, 6)};
				end
			end
			3'd2: begin
				r.cx = pbit(pl, 0, 6); r.cz = pbit(pl, 2, 3);
				if (dy) begin
					r.cy = pbit(pl, 1, 2);
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 3), pbit(pl, 4, 7), pbit(pl, 3, 6), pbit(pl, 6, 7)};
				end else begin
					r.cy = s[0];
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 2, 1), pbit(pl, 4, 7), pbit(pl, 0, 4), pbit(pl, 4, 5)};
				end
			end
			3'd3: begin
				r.cx = pbit(pl, 0, 7);
				r.cy = dy ? pbit(pl, 1, 3) : s[1];
				r.cz = dz ? pbit(pl, 2, 3) : s[2];
				if (dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 2, 1), pbit(pl, 4, 7), pbit(pl, 0, 5), pbit(pl, 4, 5)};
				else if (dy)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 2), pbit(pl, 0, 6), pbit(pl, 3, 7), pbit(pl, 3, 6)};
				else
					{r.lx, r.ly, r.lz, r.cn} =
						{s[0], pbit(pl, 0, 6), pbit(pl, 0, 5), pbit(pl, 0, 4)};
			end
			3'd4: begin
				r.cy = pbit(pl, 1, 6); r.cz = pbit(pl, 2, 5);
				if (dx) begin
					r.cx = pbit(pl, 0, 4);
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 4, 5), pbit(pl, 3, 6), pbit(pl, 6, 7)};
				end else begin
					r.cx = s[0];
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 1, 1), pbit(pl, 1, 2), pbit(pl, 5, 3)};
				end
			end
			3'd5: begin
				r.cx = dx ? pbit(pl, 0, 5) : s[1];
				r.cy = pbit(pl, 1, 7);
				r.cz = dz ? pbit(pl, 2, 5) : s[4];
				if (dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 2, 1), pbit(pl, 1, 3), pbit(pl, 5, 3)};
				else if (dx)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 6), pbit(pl, 0, 4), pbit(pl, 3, 7), pbit(pl, 3, 4)};
				else
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 6), s[0], pbit(pl, 1, 3), pbit(pl, 1, 2)};
			end
			3'd6: begin
				r.cx = dx ? pbit(pl, 0, 6) : s[2];
				r.cy = dy ? pbit(pl, 1, 6) : s[4];
				r.cz = pbit(pl, 2, 7);
				if (dx && dy)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 4, 7), pbit(pl, 3, 6), pbit(pl, 6, 7)};
				else if (dx)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 2, 5), pbit(pl, 4, 7), pbit(pl, 0, 4), pbit(pl, 4, 5)};
				else if (dy)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 5), pbit(pl, 2, 3), pbit(pl, 1, 2), pbit(pl, 5, 3)};
				else
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 2, 5), pbit(pl, 2, 3), s[0], pbit(pl, 2, 1)};
			end
			default: begin
				r.cx = dx ? pbit(pl, 0, 7) : s[3];
				r.cy = dy ? pbit(pl, 1, 7) : s[5];
				r.cz = dz ? pbit(pl, 2, 7) : s[6];
				if (dx && dy && dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 4, 7), pbit(pl, 3, 7), pbit(pl, 6, 7)};
				else if (dx && dy)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 6), pbit(pl, 0, 6), pbit(pl, 3, 7), pbit(pl, 3, 6)};
				else if (dx && dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 5), pbit(pl, 4, 7), pbit(pl, 0, 5), pbit(pl, 4, 5)};
				else if (dy && dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 5, 7), pbit(pl, 2, 3), pbit(pl, 0, 3), pbit(pl, 5, 3)};
				else if (dx)
					{r.lx, r.ly, r.lz, r.cn} =
						{s[4], pbit(pl, 0, 6), pbit(pl, 0, 5), pbit(pl, 0, 4)};
				else if (dy)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 1, 6), s[2], pbit(pl, 1, 3), pbit(pl, 1, 2)};
				else if (dz)
					{r.lx, r.ly, r.lz, r.cn} =
						{pbit(pl, 2, 5), pbit(pl, 2, 3), s[1], pbit(pl, 2, 1)};
				else
					{r.lx, r.ly, r.lz, r.cn} = {s[4], s[2], s[1], s[0]};
			end
		endcase
		return r;
	endfunction

	function automatic logic [PlaneBitsW-1:0] random_planes();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[PlaneBitsW-1:0];
	endfunction

	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_child(input logic [2:0] c, input logic [2:0] sk,
			input logic [PlaneBitsW-1:0] pl, input logic [SiblingW-1:0] s);
		child_item_t item;
		item.child = c;
		item.skip = sk;
		item.planes = pl;
		item.siblings = s;
		pending_children.push_back(item);
		total_items++;
	endtask

	task automatic check_bit(input string field, input logic want, input logic got);
		if (got !== want) begin
			$error("%s mismatch: expected %0b, actual %0b", field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : driver
		child_item_t item;
		if (arst_n) begin
			if (start && !busy) begin
				expected_contexts.push_back(select_context(child_index, skip_mask, plane_bits,
					sibling_bits));
				accepted_count++;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_children.size() != 0) begin
					item = pending_children.pop_front();
					child_index <= item.child;
					skip_mask <= item.skip;
					plane_bits <= item.planes;
					sibling_bits <= item.siblings;
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		ctx_t want;
		if (arst_n && done) begin
			if (expected_contexts.size() == 0) begin
				$error("result strobe with no transaction outstanding");
				error_count++;
			end else begin
				want = expected_contexts.pop_front();
				check_bit("ctx_child_x", want.cx, ctx_child_x);
				check_bit("ctx_child_y", want.cy, ctx_child_y);
				check_bit("ctx_child_z", want.cz, ctx_child_z);
				check_bit("ctx_lean_x", want.lx, ctx_lean_x);
				check_bit("ctx_lean_y", want.ly, ctx_lean_y);
				check_bit("ctx_lean_z", want.lz, ctx_lean_z);
				check_bit("ctx_corner", want.cn, ctx_corner);
				checked_count++;
			end
		end
	end

	initial begin
		#5000000;
		$display("Timeout with %0d transactions outstanding.", expected_contexts.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : sequencer
		int drain;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		child_index = '0;
		skip_mask = '0;
		plane_bits = '0;
		sibling_bits = '0;

		for (int c = 0; c < 8; c++) begin
			add_child(3'(c), 3'b000, random_planes(), 7'($urandom));
			add_child(3'(c), 3'b111, random_planes(), 7'($urandom));
		end
		// Child 3 and child 5 with both of their skip flags set: the z-skip selection wins.
		add_child(3'd3, 3'b011, random_planes(), 7'($urandom));
		add_child(3'd5, 3'b101, random_planes(), 7'($urandom));
		add_child(3'd0, 3'b000, '0, '0);
		add_child(3'd7, 3'b000, '0, '0);
		add_child(3'd7, 3'b111, '1, '1);
		add_child(3'd7, 3'b000, '1, '1);
		directed_items = total_items;
		for (int n = 0; n < 1300; n++)
			add_child(3'($urandom), 3'($urandom), random_planes(), 7'($urandom));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_items)
			@(posedge clk);
		drain = 0;
		while (expected_contexts.size() != 0 && drain < DrainLimit) begin
			@(posedge clk);
			drain++;
		end
		repeat (FlushCycles) @(posedge clk);
		if (expected_contexts.size() != 0) begin
			$error("%0d transactions never produced a result", expected_contexts.size());
			error_count++;
		end

		$display("Checked %0d child context selections: %0d directed, %0d random.",
			checked_count, directed_items, total_items - directed_items);
		$display("All child indexes and skip masks were driven with random idle gaps.");
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ocnc_pkg.sv
sv/ocnc_select.sv
sv/octree_child_neighbour_context_select_core.sv
sv/ocnc_checker.sv
test/octree_child_neighbour_context_select_core_tb.sv
